// File: hdl/dhtr_pkg.sv
package dhtr_pkg;

	localparam int MaxTransitions = 85;
	localparam int FrameBytes     = 5;
	localparam int FrameBits      = 40;
	localparam int ByteW          = 8;
	localparam int BitCountW      = 6;
	localparam int TransIdxW      = 7;
	localparam int FirstDataTrans = 4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DRIVE,
		PH_RELEASE,
		PH_LISTEN
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_CHECKSUM,
		ST_SHORT
	} status_t;

	localparam logic [1:0] CFG_START_LOW = 2'd0;
	localparam logic [1:0] CFG_RELEASE   = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [FrameBytes-1:0][ByteW-1:0] frame_t;

	// control from the sequencer to the frame store
	typedef struct packed {
		logic commit;   // apply this item's update
		logic clear;    // start of a read
		logic shift;    // period ended on a data slot
		logic bit_val;  // data bit for that slot
	} frame_ctl_t;

endpackage

// File: hdl/single_wire_humidity_sensor_reader_core.sv
// Single-wire humidity/temperature sensor reader.
// Input stream (s_*): one transaction per event. s_tuser[0] is the action
// (0 = start a read, 1 = one microsecond tick); s_tdata[0] is the sampled
// data line level. Every input transaction yields exactly one result
// transaction on m_* describing the state after that item: line drive,
// busy, done, and on the finishing item the status and four data bytes.
// Configuration (cfg_we/cfg_index/cfg_wdata) sets start-low length,
// release length, bit threshold and timeout; write only while idle.
// An accepted item is registered in the input stage, and its result is then
// registered in the result register, which drives m_tvalid.
// Throughput: one item per cycle while the output is not stalled; the whole
// per-item update (phase timer, level timer, frame store) is one pass of
// logic between the input stage and the result register.
// Stall: while m_tready is low the result register holds; one more item is
// held in the input stage, then s_tready drops until the result is taken.
// Reset: asynchronous, clears both stages, returns the sequencer to idle,
// empties the frame store and loads the register defaults
// (18000, 40, 16, 255).
module single_wire_humidity_sensor_reader_core import dhtr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
	input  logic [0:0]  s_tuser,   // [0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
	// [12:5] humidity_int, [20:13] humidity_frac, [28:21] temp_int,
	// [36:29] temp_frac, [39:37] zero
	output logic [39:0] m_tdata,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// configuration registers
	logic [15:0] start_low_q;
	logic [7:0]  release_q;
	logic [7:0]  threshold_q;
	logic [7:0]  timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q <= 16'd18000;
			release_q   <= 8'd40;
			threshold_q <= 8'd16;
			timeout_q   <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_LOW: start_low_q <= cfg_wdata;
				CFG_RELEASE:   release_q   <= cfg_wdata[7:0];
				CFG_THRESHOLD: threshold_q <= cfg_wdata[7:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// handshake: input stage feeds result register
	logic item_valid_s1;
	logic item_act_s1;
	logic item_line_s1;
	logic res_valid_s2;
	logic out_free;
	logic advance;

	assign out_free = !res_valid_s2 || m_tready;
	assign advance  = item_valid_s1 && out_free;
	assign s_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_act_s1  <= s_tuser[0];
			item_line_s1 <= s_tdata[0];
		end
	end

	// sequencer state
	phase_t               phase_q, phase_nx;
	logic [15:0]          timer_q, timer_nx;
	logic [7:0]           len_q, len_nx;
	logic                 prev_q, prev_nx;
	logic [TransIdxW-1:0] tidx_q, tidx_nx;
	logic                 done;
	logic [16:0]          timer_inc;
	logic [7:0]           len_inc;
	frame_ctl_t           fctl;
	frame_t               bytes_nx;
	status_t              status_nx;

	assign timer_inc = {1'b0, timer_q} + 17'd1;
	assign len_inc   = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			len_q   <= '0;
			prev_q  <= 1'b1;
			tidx_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_nx;
			timer_q <= timer_nx;
			len_q   <= len_nx;
			prev_q  <= prev_nx;
			tidx_q  <= tidx_nx;
		end
	end

	always_comb begin
		phase_nx     = phase_q;
		timer_nx     = timer_q;
		len_nx       = len_q;
		prev_nx      = prev_q;
		tidx_nx      = tidx_q;
		done         = 1'b0;
		fctl.commit  = advance;
		fctl.clear   = 1'b0;
		fctl.shift   = 1'b0;
		fctl.bit_val = len_q > threshold_q;
		if (!item_act_s1) begin
			// start (or restart) a read
			fctl.clear = 1'b1;
			phase_nx   = PH_DRIVE;
			timer_nx   = '0;
			len_nx     = '0;
			prev_nx    = 1'b1;
			tidx_nx    = '0;
		end else begin
			case (phase_q)
				PH_DRIVE: begin
					// timer wrap also ends the low pulse
					if (timer_inc[16] || (timer_inc[15:0] >= start_low_q)) begin
						phase_nx = PH_RELEASE;
						timer_nx = '0;
					end else begin
						timer_nx = timer_inc[15:0];
					end
				end
				PH_RELEASE: begin
					if (timer_inc[15:0] >= {8'd0, release_q}) begin
						phase_nx = PH_LISTEN;
						timer_nx = '0;
					end else begin
						timer_nx = timer_inc[15:0];
					end
				end
				PH_LISTEN: begin
					if (item_line_s1 == prev_q) begin
						len_nx = len_inc;
						done   = len_inc >= timeout_q;
					end else begin
						// period ended; periods with an even index from index 4 (the fifth) on carry data
						fctl.shift = (tidx_q >= TransIdxW'(FirstDataTrans)) && !tidx_q[0];
						prev_nx    = item_line_s1;
						len_nx     = '0;
						tidx_nx    = tidx_q + 1'b1;
						done       = tidx_nx >= TransIdxW'(MaxTransitions);
					end
					if (done) begin
						phase_nx = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	dhtr_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fctl),
		.bytes_nx  (bytes_nx),
		.status_nx (status_nx)
	);

	// result register
	logic [39:0] res_data_s2;
	logic [39:0] res_data;

	always_comb begin
		res_data      = '0;
		res_data[0]   = phase_nx == PH_DRIVE;
		res_data[1]   = phase_nx != PH_IDLE;
		res_data[2]   = done;
		if (done) begin
			res_data[4:3]   = status_nx;
			res_data[12:5]  = bytes_nx[0];
			res_data[20:13] = bytes_nx[1];
			res_data[28:21] = bytes_nx[2];
			res_data[36:29] = bytes_nx[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_data_s2 <= res_data;
		end
	end

	assign m_tvalid = res_valid_s2;
	assign m_tdata  = res_data_s2;

endmodule

// File: hdl/dhtr_frame.sv
module dhtr_frame import dhtr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  frame_ctl_t ctl,
	output frame_t     bytes_nx,
	output status_t    status_nx
);

	frame_t                bytes_q;
	logic [BitCountW-1:0]  bit_count_q;
	logic [BitCountW-1:0]  bit_count_nx;
	logic [2:0]            byte_sel;
	byte_t                 sum;

	assign byte_sel = bit_count_q[5:3];

	always_comb begin
		bytes_nx     = bytes_q;
		bit_count_nx = bit_count_q;
		if (ctl.clear) begin
			bytes_nx     = '0;
			bit_count_nx = '0;
		end else if (ctl.shift && (bit_count_q < BitCountW'(FrameBits))) begin
			for (int i = 0; i < FrameBytes; i++) begin
				if (byte_sel == 3'(i)) begin
					bytes_nx[i] = {bytes_q[i][ByteW-2:0], ctl.bit_val};
				end
			end
			bit_count_nx = bit_count_q + 1'b1;
		end
	end

	// checksum is the low byte of the sum of the first four
	assign sum = bytes_nx[0] + bytes_nx[1] + bytes_nx[2] + bytes_nx[3];

	always_comb begin
		if (bit_count_nx < BitCountW'(FrameBits)) begin
			status_nx = ST_SHORT;
		end else if (sum == bytes_nx[4]) begin
			status_nx = ST_OK;
		end else begin
			status_nx = ST_CHECKSUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q     <= '0;
			bit_count_q <= '0;
		end else if (ctl.commit) begin
			bytes_q     <= bytes_nx;
			bit_count_q <= bit_count_nx;
		end
	end

endmodule
